/* rtl/cvh_pkg.sv */
package cvh_pkg;

  // Smallest hull size and the stack guard depth
  localparam int HULL_MIN  = 3;
  localparam int STK_GUARD = 2;

  typedef enum logic [4:0] {
    S_LOAD, S_SWAP0, S_SWAP1,
    S_SORT_I, S_SORT_T, S_SORT_J, S_SORT_U, S_SORT_G, S_SORT_W,
    S_DED_START, S_DED_A, S_DED_N, S_DED_B, S_DED_G, S_DED_W,
    S_CHECK, S_SC_INIT1, S_SC_INIT2, S_SC_INIT3,
    S_SC_I, S_SC_C, S_SC_T, S_SC_W, S_SC_P1, S_SC_P2,
    S_EM_RD, S_EM_S, S_EM_L, S_EM_EMPTY, S_EM_O
  } state_t;

  // Write data source for the point store
  typedef enum logic [1:0] {WD_P0, WD_PIV, WD_T, WD_U} wd_sel_t;

  // Operand set for the orientation unit
  typedef enum logic [1:0] {CMP_SORT, CMP_DEDUP, CMP_SCAN} cmp_sel_t;

  typedef struct packed {
    logic     ld_pt;
    logic     wk_rd_en;
    logic     wk_wr_en;
    wd_sel_t  wd_sel;
    logic     stk_wr_en;
    logic     ld_t_rd;
    logic     ld_t_u;
    logic     ld_u_rd;
    logic     ld_s2_rd;
    logic     ld_s1_rd;
    logic     ld_s1_s2;
    logic     push;
    logic     cmp_go;
    cmp_sel_t cmp_sel;
    logic     ld_out;
    logic     out_empty;
    logic     out_last;
    logic     clr_cnt;
  } cvh_cmd_t;

  typedef struct packed {
    logic cmp_done;
    logic cmp_after;
    logic cmp_zero;
    logic cmp_neg;
  } cvh_stat_t;

endpackage

/* rtl/convex_hull_graham_scan.sv */
// Convex hull of a point set by Graham scan.
// Input channel: one point per beat (in_pt_x, in_pt_y). A beat with
// in_final_point set closes the set and starts the hull run. Points beyond
// MAX_POINTS are discarded; a final beat still starts the run.
// Output channel: hull vertices in stack-pop order, ending with the pivot
// (lowest y, then lowest x), flagged by out_last_vertex. With fewer than
// two distinct angles about the pivot, a single beat with out_hull_empty set
// and zero coordinates is sent.
// Throughput: points load one per cycle. The run then walks the
// point store through one read port and a 3-stage orientation unit: the
// insertion sort (O(n^2) comparisons worst case), then compaction of
// points that share an angle, the stack scan with its pushes and pops,
// and the output of each vertex.
// in_ready is high only while loading; one set is handled at a time.
// A stalled receiver holds the current vertex in the output register and
// the run waits until it is taken.
// Reset (synchronous, rst_n low) empties the point set and returns the
// block to loading; the point and stack stores need no clearing.
module convex_hull_graham_scan #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_pt_x,
  input  logic signed [COORD_BITS-1:0] in_pt_y,
  input  logic                         in_final_point,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_hull_x,
  output logic signed [COORD_BITS-1:0] out_hull_y,
  output logic                         out_last_vertex,
  output logic                         out_hull_empty
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  cvh_pkg::cvh_cmd_t  cmd;
  cvh_pkg::cvh_stat_t stat;
  logic [CW-1:0] cnt;
  logic [AW-1:0] piv_idx, stk_q;
  logic [AW-1:0] wk_rd_addr, wk_wr_addr, stk_rd_addr, stk_wr_addr, stk_wr_data;

  // Sequencer
  cvh_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_final    (in_final_point),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stat        (stat),
    .cnt         (cnt),
    .piv_idx     (piv_idx),
    .stk_q       (stk_q),
    .cmd         (cmd),
    .wk_rd_addr  (wk_rd_addr),
    .wk_wr_addr  (wk_wr_addr),
    .stk_rd_addr (stk_rd_addr),
    .stk_wr_addr (stk_wr_addr),
    .stk_wr_data (stk_wr_data)
  );

  // Stores, point registers and orientation unit
  cvh_dp #(
    .MAX_POINTS (MAX_POINTS),
    .CB         (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_x        (in_pt_x),
    .in_y        (in_pt_y),
    .wk_rd_addr  (wk_rd_addr),
    .wk_wr_addr  (wk_wr_addr),
    .stk_rd_addr (stk_rd_addr),
    .stk_wr_addr (stk_wr_addr),
    .stk_wr_data (stk_wr_data),
    .stat        (stat),
    .cnt         (cnt),
    .piv_idx     (piv_idx),
    .stk_q       (stk_q),
    .out_x       (out_hull_x),
    .out_y       (out_hull_y),
    .out_last    (out_last_vertex),
    .out_empty   (out_hull_empty)
  );

endmodule

/* rtl/cvh_cross.sv */
module cvh_cross #(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic                 is_after,
  input  logic signed [CB-1:0] px,
  input  logic signed [CB-1:0] py,
  input  logic signed [CB-1:0] qx,
  input  logic signed [CB-1:0] qy,
  input  logic signed [CB-1:0] rx,
  input  logic signed [CB-1:0] ry,
  output logic                 done,
  output logic                 after,
  output logic                 zero,
  output logic                 neg
);

  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int MW = DW + 1;

  logic signed [DW-1:0] qpx, qpy, rpx, rpy, rqx, rqy;
  logic signed [DW-1:0] a0, b0, c0, d0;
  logic signed [DW-1:0] a1_r, b1_r, c1_r, d1_r;
  logic signed [PW-1:0] p1_r, p2_r;
  logic [DW-1:0]        ma, mb, mc, md;
  logic [MW-1:0]        da_r, db_r;
  logic signed [SW-1:0] sdiff;
  logic                 v1_r, v2_r, v3_r;
  logic                 after_r, zero_r, neg_r;

  // Coordinate differences and operand choice
  assign qpx = DW'(qx) - DW'(px);
  assign qpy = DW'(qy) - DW'(py);
  assign rpx = DW'(rx) - DW'(px);
  assign rpy = DW'(ry) - DW'(py);
  assign rqx = DW'(rx) - DW'(qx);
  assign rqy = DW'(ry) - DW'(qy);
  assign a0  = is_after ? qpx : qpy;
  assign b0  = is_after ? rpy : rqx;
  assign c0  = is_after ? qpy : qpx;
  assign d0  = is_after ? rpx : rqy;

  // Stage 1: operands
  always_ff @(posedge clk) begin
    if (go) begin
      a1_r <= a0;
      b1_r <= b0;
      c1_r <= c0;
      d1_r <= d0;
    end
  end

  // Stage 2: products and L1 distances
  assign ma = a1_r[DW-1] ? DW'(-a1_r) : DW'(a1_r);
  assign mb = b1_r[DW-1] ? DW'(-b1_r) : DW'(b1_r);
  assign mc = c1_r[DW-1] ? DW'(-c1_r) : DW'(c1_r);
  assign md = d1_r[DW-1] ? DW'(-d1_r) : DW'(d1_r);

  always_ff @(posedge clk) begin
    p1_r <= PW'(a1_r) * PW'(b1_r);
    p2_r <= PW'(c1_r) * PW'(d1_r);
    da_r <= MW'(ma) + MW'(mc);
    db_r <= MW'(md) + MW'(mb);
  end

  // Stage 3: sign of the difference
  assign sdiff = SW'(p1_r) - SW'(p2_r);

  always_ff @(posedge clk) begin
    zero_r <= (sdiff == '0);
    neg_r  <= sdiff[SW-1];
    if (da_r != '0 && db_r != '0 && sdiff != '0) begin
      after_r <= sdiff[SW-1];
    end else begin
      after_r <= (da_r > db_r);
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign done  = v3_r;
  assign after = after_r;
  assign zero  = zero_r;
  assign neg   = neg_r;

endmodule

/* rtl/cvh_dp.sv */
module cvh_dp #(
  parameter int MAX_POINTS = 64,
  parameter int CB         = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cvh_pkg::cvh_cmd_t                      cmd,
  input  logic signed [CB-1:0]                   in_x,
  input  logic signed [CB-1:0]                   in_y,
  input  logic [$clog2(MAX_POINTS)-1:0]          wk_rd_addr,
  input  logic [$clog2(MAX_POINTS)-1:0]          wk_wr_addr,
  input  logic [$clog2(MAX_POINTS)-1:0]          stk_rd_addr,
  input  logic [$clog2(MAX_POINTS)-1:0]          stk_wr_addr,
  input  logic [$clog2(MAX_POINTS)-1:0]          stk_wr_data,
  output cvh_pkg::cvh_stat_t                     stat,
  output logic [$clog2(MAX_POINTS+1)-1:0]        cnt,
  output logic [$clog2(MAX_POINTS)-1:0]          piv_idx,
  output logic [$clog2(MAX_POINTS)-1:0]          stk_q,
  output logic signed [CB-1:0]                   out_x,
  output logic signed [CB-1:0]                   out_y,
  output logic                                   out_last,
  output logic                                   out_empty
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [2*CB-1:0] wk_mem [MAX_POINTS];
  logic [AW-1:0]   stk_mem [MAX_POINTS];
  logic [2*CB-1:0] wk_q_r;
  logic [AW-1:0]   stk_q_r;
  logic [CW-1:0]   cnt_r;
  logic [AW-1:0]   piv_r;
  logic signed [CB-1:0] p0x_r, p0y_r, pvx_r, pvy_r;
  logic signed [CB-1:0] tx_r, ty_r, ux_r, uy_r;
  logic signed [CB-1:0] s1x_r, s1y_r, s2x_r, s2y_r;
  logic signed [CB-1:0] qx_s, qy_s;
  logic signed [CB-1:0] ox_r, oy_r;
  logic            olast_r, oempty_r;
  logic            store_ok;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [2*CB-1:0] wr_data;
  logic signed [CB-1:0] cpx, cpy, cqx, cqy, crx, cry;
  logic            c_after;

  assign store_ok = cmd.ld_pt && (cnt_r < CW'(MAX_POINTS));
  assign qx_s     = wk_q_r[2*CB-1:CB];
  assign qy_s     = wk_q_r[CB-1:0];

  // Store write port: loading beats or pivot swap, sort and compact writes
  always_comb begin
    wr_en   = cmd.wk_wr_en;
    wr_addr = wk_wr_addr;
    case (cmd.wd_sel)
      cvh_pkg::WD_P0:  wr_data = {p0x_r, p0y_r};
      cvh_pkg::WD_PIV: wr_data = {pvx_r, pvy_r};
      cvh_pkg::WD_T:   wr_data = {tx_r, ty_r};
      cvh_pkg::WD_U:   wr_data = {ux_r, uy_r};
      default:         wr_data = {tx_r, ty_r};
    endcase
    if (store_ok) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r[AW-1:0];
      wr_data = {in_x, in_y};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wk_mem[wr_addr] <= wr_data;
    end
    if (cmd.wk_rd_en) begin
      wk_q_r <= wk_mem[wk_rd_addr];
    end
  end

  // Hull stack of indices
  always_ff @(posedge clk) begin
    if (cmd.stk_wr_en) begin
      stk_mem[stk_wr_addr] <= stk_wr_data;
    end
    stk_q_r <= stk_mem[stk_rd_addr];
  end

  // Point count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.clr_cnt) begin
      cnt_r <= '0;
    end else if (store_ok) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // Pivot tracking while loading: lowest y, then lowest x, first wins
  always_ff @(posedge clk) begin
    if (store_ok) begin
      if (cnt_r == '0) begin
        p0x_r <= in_x;
        p0y_r <= in_y;
        pvx_r <= in_x;
        pvy_r <= in_y;
        piv_r <= '0;
      end else if (in_y < pvy_r || (in_y == pvy_r && in_x < pvx_r)) begin
        pvx_r <= in_x;
        pvy_r <= in_y;
        piv_r <= cnt_r[AW-1:0];
      end
    end
  end

  // Working point registers
  always_ff @(posedge clk) begin
    if (cmd.ld_t_rd) begin
      tx_r <= qx_s;
      ty_r <= qy_s;
    end else if (cmd.ld_t_u) begin
      tx_r <= ux_r;
      ty_r <= uy_r;
    end
    if (cmd.ld_u_rd) begin
      ux_r <= qx_s;
      uy_r <= qy_s;
    end
    if (cmd.ld_s1_rd) begin
      s1x_r <= qx_s;
      s1y_r <= qy_s;
    end else if (cmd.push) begin
      s1x_r <= ux_r;
      s1y_r <= uy_r;
    end else if (cmd.ld_s1_s2) begin
      s1x_r <= s2x_r;
      s1y_r <= s2y_r;
    end
    if (cmd.ld_s2_rd) begin
      s2x_r <= qx_s;
      s2y_r <= qy_s;
    end else if (cmd.push) begin
      s2x_r <= s1x_r;
      s2y_r <= s1y_r;
    end
  end

  // Orientation operands
  always_comb begin
    case (cmd.cmp_sel)
      cvh_pkg::CMP_SORT: begin
        cpx = pvx_r; cpy = pvy_r;
        cqx = ux_r;  cqy = uy_r;
        crx = tx_r;  cry = ty_r;
      end
      cvh_pkg::CMP_DEDUP: begin
        cpx = pvx_r; cpy = pvy_r;
        cqx = tx_r;  cqy = ty_r;
        crx = ux_r;  cry = uy_r;
      end
      cvh_pkg::CMP_SCAN: begin
        cpx = s2x_r; cpy = s2y_r;
        cqx = s1x_r; cqy = s1y_r;
        crx = ux_r;  cry = uy_r;
      end
      default: begin
        cpx = pvx_r; cpy = pvy_r;
        cqx = tx_r;  cqy = ty_r;
        crx = ux_r;  cry = uy_r;
      end
    endcase
  end

  assign c_after = (cmd.cmp_sel == cvh_pkg::CMP_SORT);

  cvh_cross #(
    .CB (CB)
  ) u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.cmp_go),
    .is_after (c_after),
    .px       (cpx),
    .py       (cpy),
    .qx       (cqx),
    .qy       (cqy),
    .rx       (crx),
    .ry       (cry),
    .done     (stat.cmp_done),
    .after    (stat.cmp_after),
    .zero     (stat.cmp_zero),
    .neg      (stat.cmp_neg)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      ox_r     <= cmd.out_empty ? '0 : qx_s;
      oy_r     <= cmd.out_empty ? '0 : qy_s;
      olast_r  <= cmd.out_last;
      oempty_r <= cmd.out_empty;
    end
  end

  assign cnt       = cnt_r;
  assign piv_idx   = piv_r;
  assign stk_q     = stk_q_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_last  = olast_r;
  assign out_empty = oempty_r;

endmodule

/* rtl/cvh_ctrl.sv */
module cvh_ctrl #(
  parameter int MAX_POINTS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_final,
  output logic                               in_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  input  cvh_pkg::cvh_stat_t                 stat,
  input  logic [$clog2(MAX_POINTS+1)-1:0]    cnt,
  input  logic [$clog2(MAX_POINTS)-1:0]      piv_idx,
  input  logic [$clog2(MAX_POINTS)-1:0]      stk_q,
  output cvh_pkg::cvh_cmd_t                  cmd,
  output logic [$clog2(MAX_POINTS)-1:0]      wk_rd_addr,
  output logic [$clog2(MAX_POINTS)-1:0]      wk_wr_addr,
  output logic [$clog2(MAX_POINTS)-1:0]      stk_rd_addr,
  output logic [$clog2(MAX_POINTS)-1:0]      stk_wr_addr,
  output logic [$clog2(MAX_POINTS)-1:0]      stk_wr_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  cvh_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, m_r, m_nxt, d_r, d_nxt;
  logic [CW-1:0] i_p1, j_m1, d_m1, d_m3;

  assign i_p1 = i_r + CW'(1);
  assign j_m1 = j_r - CW'(1);
  assign d_m1 = d_r - CW'(1);
  assign d_m3 = d_r - CW'(3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cvh_pkg::S_LOAD;
      i_r     <= '0;
      j_r     <= '0;
      m_r     <= '0;
      d_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      m_r     <= m_nxt;
      d_r     <= d_nxt;
    end
  end

  // Next state and loop counters
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    m_nxt     = m_r;
    d_nxt     = d_r;
    unique case (state_r)
      cvh_pkg::S_LOAD: begin
        if (in_valid && in_final) begin
          d_nxt     = '0;
          state_nxt = cvh_pkg::S_SWAP0;
        end
      end
      cvh_pkg::S_SWAP0: state_nxt = cvh_pkg::S_SWAP1;
      cvh_pkg::S_SWAP1: begin
        i_nxt     = CW'(2);
        state_nxt = cvh_pkg::S_SORT_I;
      end
      cvh_pkg::S_SORT_I: begin
        state_nxt = (i_r < cnt) ? cvh_pkg::S_SORT_T : cvh_pkg::S_DED_START;
      end
      cvh_pkg::S_SORT_T: begin
        j_nxt     = i_r;
        state_nxt = cvh_pkg::S_SORT_J;
      end
      cvh_pkg::S_SORT_J: begin
        if (j_r <= CW'(1)) begin
          i_nxt     = i_p1;
          state_nxt = cvh_pkg::S_SORT_I;
        end else begin
          state_nxt = cvh_pkg::S_SORT_U;
        end
      end
      cvh_pkg::S_SORT_U: state_nxt = cvh_pkg::S_SORT_G;
      cvh_pkg::S_SORT_G: state_nxt = cvh_pkg::S_SORT_W;
      cvh_pkg::S_SORT_W: begin
        if (stat.cmp_done) begin
          if (stat.cmp_after) begin
            j_nxt     = j_m1;
            state_nxt = cvh_pkg::S_SORT_J;
          end else begin
            i_nxt     = i_p1;
            state_nxt = cvh_pkg::S_SORT_I;
          end
        end
      end
      cvh_pkg::S_DED_START: begin
        m_nxt     = CW'(1);
        i_nxt     = CW'(1);
        state_nxt = (cnt >= CW'(2)) ? cvh_pkg::S_DED_A : cvh_pkg::S_CHECK;
      end
      cvh_pkg::S_DED_A: state_nxt = cvh_pkg::S_DED_N;
      cvh_pkg::S_DED_N: begin
        if (i_p1 >= cnt) begin
          m_nxt     = m_r + CW'(1);
          state_nxt = cvh_pkg::S_CHECK;
        end else begin
          state_nxt = cvh_pkg::S_DED_B;
        end
      end
      cvh_pkg::S_DED_B: state_nxt = cvh_pkg::S_DED_G;
      cvh_pkg::S_DED_G: state_nxt = cvh_pkg::S_DED_W;
      cvh_pkg::S_DED_W: begin
        if (stat.cmp_done) begin
          if (!stat.cmp_zero) begin
            m_nxt = m_r + CW'(1);
          end
          i_nxt     = i_p1;
          state_nxt = cvh_pkg::S_DED_N;
        end
      end
      cvh_pkg::S_CHECK: begin
        state_nxt = (m_r >= CW'(cvh_pkg::HULL_MIN)) ? cvh_pkg::S_SC_INIT1
                                                    : cvh_pkg::S_EM_EMPTY;
      end
      cvh_pkg::S_SC_INIT1: state_nxt = cvh_pkg::S_SC_INIT2;
      cvh_pkg::S_SC_INIT2: state_nxt = cvh_pkg::S_SC_INIT3;
      cvh_pkg::S_SC_INIT3: begin
        d_nxt     = CW'(cvh_pkg::HULL_MIN);
        i_nxt     = CW'(cvh_pkg::HULL_MIN);
        state_nxt = cvh_pkg::S_SC_I;
      end
      cvh_pkg::S_SC_I: begin
        state_nxt = (i_r < m_r) ? cvh_pkg::S_SC_C : cvh_pkg::S_EM_RD;
      end
      cvh_pkg::S_SC_C: state_nxt = cvh_pkg::S_SC_T;
      cvh_pkg::S_SC_T: begin
        if (d_r > CW'(cvh_pkg::STK_GUARD)) begin
          state_nxt = cvh_pkg::S_SC_W;
        end else begin
          d_nxt     = d_r + CW'(1);
          i_nxt     = i_p1;
          state_nxt = cvh_pkg::S_SC_I;
        end
      end
      cvh_pkg::S_SC_W: begin
        if (stat.cmp_done) begin
          if (stat.cmp_neg) begin
            d_nxt     = d_r + CW'(1);
            i_nxt     = i_p1;
            state_nxt = cvh_pkg::S_SC_I;
          end else begin
            d_nxt     = d_m1;
            state_nxt = cvh_pkg::S_SC_P1;
          end
        end
      end
      cvh_pkg::S_SC_P1: state_nxt = cvh_pkg::S_SC_P2;
      cvh_pkg::S_SC_P2: state_nxt = cvh_pkg::S_SC_T;
      cvh_pkg::S_EM_RD: begin
        d_nxt     = d_m1;
        state_nxt = cvh_pkg::S_EM_S;
      end
      cvh_pkg::S_EM_S:     state_nxt = cvh_pkg::S_EM_L;
      cvh_pkg::S_EM_L:     state_nxt = cvh_pkg::S_EM_O;
      cvh_pkg::S_EM_EMPTY: state_nxt = cvh_pkg::S_EM_O;
      cvh_pkg::S_EM_O: begin
        if (out_ready) begin
          state_nxt = (d_r == '0) ? cvh_pkg::S_LOAD : cvh_pkg::S_EM_RD;
        end
      end
      default: state_nxt = cvh_pkg::S_LOAD;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd         = '0;
    cmd.wd_sel  = cvh_pkg::WD_T;
    cmd.cmp_sel = cvh_pkg::CMP_SORT;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    wk_rd_addr  = '0;
    wk_wr_addr  = '0;
    stk_rd_addr = '0;
    stk_wr_addr = '0;
    stk_wr_data = '0;
    unique case (state_r)
      cvh_pkg::S_LOAD: begin
        in_ready   = 1'b1;
        cmd.ld_pt  = in_valid;
      end
      cvh_pkg::S_SWAP0: begin
        cmd.wk_wr_en = 1'b1;
        cmd.wd_sel   = cvh_pkg::WD_P0;
        wk_wr_addr   = piv_idx;
      end
      cvh_pkg::S_SWAP1: begin
        cmd.wk_wr_en = 1'b1;
        cmd.wd_sel   = cvh_pkg::WD_PIV;
      end
      cvh_pkg::S_SORT_I: begin
        cmd.wk_rd_en = 1'b1;
        wk_rd_addr   = i_r[AW-1:0];
      end
      cvh_pkg::S_SORT_T: cmd.ld_t_rd = 1'b1;
      cvh_pkg::S_SORT_J: begin
        if (j_r <= CW'(1)) begin
          cmd.wk_wr_en = 1'b1;
          wk_wr_addr   = j_r[AW-1:0];
        end else begin
          cmd.wk_rd_en = 1'b1;
          wk_rd_addr   = j_m1[AW-1:0];
        end
      end
      cvh_pkg::S_SORT_U: cmd.ld_u_rd = 1'b1;
      cvh_pkg::S_SORT_G: cmd.cmp_go = 1'b1;
      cvh_pkg::S_SORT_W: begin
        if (stat.cmp_done) begin
          cmd.wk_wr_en = 1'b1;
          cmd.wd_sel   = stat.cmp_after ? cvh_pkg::WD_U : cvh_pkg::WD_T;
          wk_wr_addr   = j_r[AW-1:0];
        end
      end
      cvh_pkg::S_DED_START: begin
        cmd.wk_rd_en = 1'b1;
        wk_rd_addr   = AW'(1);
      end
      cvh_pkg::S_DED_A: cmd.ld_t_rd = 1'b1;
      cvh_pkg::S_DED_N: begin
        if (i_p1 >= cnt) begin
          cmd.wk_wr_en = 1'b1;
          wk_wr_addr   = m_r[AW-1:0];
        end else begin
          cmd.wk_rd_en = 1'b1;
          wk_rd_addr   = i_p1[AW-1:0];
        end
      end
      cvh_pkg::S_DED_B: cmd.ld_u_rd = 1'b1;
      cvh_pkg::S_DED_G: begin
        cmd.cmp_go  = 1'b1;
        cmd.cmp_sel = cvh_pkg::CMP_DEDUP;
      end
      cvh_pkg::S_DED_W: begin
        cmd.cmp_sel = cvh_pkg::CMP_DEDUP;
        if (stat.cmp_done) begin
          cmd.ld_t_u   = 1'b1;
          cmd.wk_wr_en = !stat.cmp_zero;
          wk_wr_addr   = m_r[AW-1:0];
        end
      end
      cvh_pkg::S_CHECK: begin
        cmd.stk_wr_en = (m_r >= CW'(cvh_pkg::HULL_MIN));
      end
      cvh_pkg::S_SC_INIT1: begin
        cmd.stk_wr_en = 1'b1;
        stk_wr_addr   = AW'(1);
        stk_wr_data   = AW'(1);
        cmd.wk_rd_en  = 1'b1;
        wk_rd_addr    = AW'(1);
      end
      cvh_pkg::S_SC_INIT2: begin
        cmd.stk_wr_en = 1'b1;
        stk_wr_addr   = AW'(2);
        stk_wr_data   = AW'(2);
        cmd.ld_s2_rd  = 1'b1;
        cmd.wk_rd_en  = 1'b1;
        wk_rd_addr    = AW'(2);
      end
      cvh_pkg::S_SC_INIT3: cmd.ld_s1_rd = 1'b1;
      cvh_pkg::S_SC_I: begin
        cmd.wk_rd_en = 1'b1;
        wk_rd_addr   = i_r[AW-1:0];
      end
      cvh_pkg::S_SC_C: cmd.ld_u_rd = 1'b1;
      cvh_pkg::S_SC_T: begin
        cmd.cmp_sel = cvh_pkg::CMP_SCAN;
        if (d_r > CW'(cvh_pkg::STK_GUARD)) begin
          cmd.cmp_go = 1'b1;
        end else begin
          cmd.push      = 1'b1;
          cmd.stk_wr_en = 1'b1;
          stk_wr_addr   = d_r[AW-1:0];
          stk_wr_data   = i_r[AW-1:0];
        end
      end
      cvh_pkg::S_SC_W: begin
        cmd.cmp_sel = cvh_pkg::CMP_SCAN;
        if (stat.cmp_done) begin
          if (stat.cmp_neg) begin
            cmd.push      = 1'b1;
            cmd.stk_wr_en = 1'b1;
            stk_wr_addr   = d_r[AW-1:0];
            stk_wr_data   = i_r[AW-1:0];
          end else begin
            cmd.ld_s1_s2 = 1'b1;
            stk_rd_addr  = d_m3[AW-1:0];
          end
        end
      end
      cvh_pkg::S_SC_P1: begin
        cmd.wk_rd_en = 1'b1;
        wk_rd_addr   = stk_q;
      end
      cvh_pkg::S_SC_P2: cmd.ld_s2_rd = 1'b1;
      cvh_pkg::S_EM_RD: stk_rd_addr = d_m1[AW-1:0];
      cvh_pkg::S_EM_S: begin
        cmd.wk_rd_en = 1'b1;
        wk_rd_addr   = stk_q;
      end
      cvh_pkg::S_EM_L: begin
        cmd.ld_out   = 1'b1;
        cmd.out_last = (d_r == '0);
      end
      cvh_pkg::S_EM_EMPTY: begin
        cmd.ld_out    = 1'b1;
        cmd.out_last  = 1'b1;
        cmd.out_empty = 1'b1;
      end
      cvh_pkg::S_EM_O: begin
        out_valid   = 1'b1;
        cmd.clr_cnt = out_ready && (d_r == '0);
      end
      default: ;
    endcase
  end

endmodule
